// File: rtl/spq_pkg.sv
package spq_pkg;

  // Field widths of one request and one response.
  localparam int unsigned DataW = 32;
  localparam int unsigned FillW = 5;

  // Default number of entries held in the cell chain.
  localparam int unsigned DefaultCapacity = 16;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // One stored entry: payload and signed priority key.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_req_if.sv
interface spq_req_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  func_e                   func;
  logic signed [DataW-1:0] value;
  logic signed [DataW-1:0] priority_req;

  modport source (output valid, func, value, priority_req, input ready);
  modport sink   (input valid, func, value, priority_req, output ready);
endinterface

// File: rtl/spq_rsp_if.sv
interface spq_rsp_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] out_value;
  logic signed [DataW-1:0] out_priority;
  status_e                 status;
  logic [FillW-1:0]        fill;

  modport source (output valid, out_value, out_priority, status, fill, input ready);
  modport sink   (input valid, out_value, out_priority, status, fill, output ready);
endinterface

// File: rtl/spq_cell.sv
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                prev_behind_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output spq_pkg::entry_t     entry_o,
  output logic                behind_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // The new entry goes behind this cell when the stored key is strictly smaller.
  assign behind_o = occ_i && (entry_q.prio < ctrl_i.new_entry.prio);

  // Insert: keep, take the new entry at the boundary, or take the left neighbor.
  // Remove: take the right neighbor. Otherwise the cell holds its entry.
  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.insert) begin
      if (!behind_o) begin
        entry_d = prev_behind_i ? ctrl_i.new_entry : left_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/sorted_priority_queue.sv
// Channel  Direction  Fields                                   Beat
// in_i     sink       func, value, priority_req                valid & ready
// out_o    source     out_value, out_priority, status, fill    valid & ready
//
// Every request beat yields one response beat, held in the response register.
// A new request is taken each cycle while the response register is empty or
// being drained, so the chain sustains one operation per cycle.
// All cells compare against the new key in parallel and shift together.
// Reset clears the entry count and the response valid; cell contents are
// only read below the count. A stalled response holds off new requests.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  spq_req_if.sink  in_i,
  spq_rsp_if.source out_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic signed [DataW-1:0] out_value_q, out_value_d;
  logic signed [DataW-1:0] out_prio_q, out_prio_d;
  status_e          out_status_q, out_status_d;
  logic [FillW-1:0] out_fill_q;
  logic [CntW+FillW-1:0] fill_ext;

  logic       fire, is_full, is_empty, insert_ok, remove_ok;
  cell_ctrl_t ctrl;

  entry_t entries [CAPACITY];
  logic   behind  [CAPACITY];

  // Handshake: accept whenever the response register can take the result.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign is_full   = (count_q >= CntW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign insert_ok = fire && (in_i.func == FUNC_INSERT) && !is_full;
  assign remove_ok = fire && (in_i.func == FUNC_REMOVE) && !is_empty;

  assign ctrl.insert          = insert_ok;
  assign ctrl.remove          = remove_ok;
  assign ctrl.new_entry.value = in_i.value;
  assign ctrl.new_entry.prio  = in_i.priority_req;

  // Chain of cells; cell 0 is the front of the queue.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   prev_behind;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_behind = 1'b1;
      assign left_entry  = ctrl.new_entry;
    end else begin : g_body
      assign prev_behind = behind[i-1];
      assign left_entry  = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ),
      .prev_behind_i (prev_behind),
      .left_i        (left_entry),
      .right_i       (right_entry),
      .entry_o       (entries[i]),
      .behind_o      (behind[i])
    );
  end

  // Next count and response fields.
  always_comb begin
    count_d      = count_q;
    out_value_d  = '0;
    out_prio_d   = '0;
    out_status_d = STATUS_DONE;
    unique case (in_i.func)
      FUNC_INSERT: begin
        if (is_full) begin
          out_status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      FUNC_REMOVE: begin
        if (is_empty) begin
          out_status_d = STATUS_EMPTY;
        end else begin
          count_d     = count_q - CntW'(1);
          out_value_d = entries[0].value;
          out_prio_d  = entries[0].prio;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign fill_ext = {{FillW{1'b0}}, count_d};

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_value_q  <= out_value_d;
      out_prio_q   <= out_prio_d;
      out_status_q <= out_status_d;
      out_fill_q   <= fill_ext[FillW-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_value    = out_value_q;
  assign out_o.out_priority = out_prio_q;
  assign out_o.status       = out_status_q;
  assign out_o.fill         = out_fill_q;

  // The count never runs past the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Every accepted request produces a response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted request produced no response");

  // A successful insert grows the count by one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert_ok |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the count");

  // The two front cells stay in ascending priority order.
  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entries[0].prio <= entries[1].prio))
    else $error("front of chain out of order");

endmodule

// File: tb/sv/spq_order_checker.sv
// Watches the request and response channels of the priority queue, keeps its
// own sorted copy of the stored entries and checks every response beat.
module spq_order_checker #(
  parameter int unsigned Capacity = spq_pkg::DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if          req_i,
  spq_rsp_if          rsp_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
    status_e                 status;
    logic [FillW-1:0]        fill;
  } rsp_beat_t;

  // Entries in ascending priority order, slot 0 leaves first.
  entry_t    sorted_entries [Capacity];
  int        held;
  rsp_beat_t expected_rsp_q [$];
  int        errors;

  // Apply one request to the sorted copy and return the response it causes.
  function automatic rsp_beat_t apply_request(func_e op, logic signed [DataW-1:0] val,
                                              logic signed [DataW-1:0] pri);
    rsp_beat_t rsp;
    int        pos;
    rsp = '{value: '0, prio: '0, status: STATUS_DONE, fill: '0};
    if (op == FUNC_INSERT) begin
      if (held >= Capacity) begin
        rsp.status = STATUS_FULL;
      end else begin
        // The new entry goes ahead of the first equal or greater key.
        pos = 0;
        while (pos < held && sorted_entries[pos].prio < pri) pos++;
        for (int i = held; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
        sorted_entries[pos] = '{value: val, prio: pri};
        held++;
      end
    end else begin
      if (held == 0) begin
        rsp.status = STATUS_EMPTY;
      end else begin
        rsp.value = sorted_entries[0].value;
        rsp.prio  = sorted_entries[0].prio;
        for (int i = 1; i < held; i++) sorted_entries[i-1] = sorted_entries[i];
        held--;
      end
    end
    rsp.fill = FillW'(held);
    return rsp;
  endfunction

  // Responses are checked before the request of the same edge is predicted,
  // so a beat can only ever match an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_beat_t exp_rsp;
    if (!rst_ni) begin
      held = 0;
      errors = 0;
      expected_rsp_q.delete();
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response beat with no request outstanding");
          errors++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_i.out_value !== exp_rsp.value) begin
            $error("out_value: expected %0d, got %0d", exp_rsp.value, rsp_i.out_value);
            errors++;
          end
          if (rsp_i.out_priority !== exp_rsp.prio) begin
            $error("out_priority: expected %0d, got %0d", exp_rsp.prio, rsp_i.out_priority);
            errors++;
          end
          if (rsp_i.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_i.status);
            errors++;
          end
          if (rsp_i.fill !== exp_rsp.fill) begin
            $error("fill: expected %0d, got %0d", exp_rsp.fill, rsp_i.fill);
            errors++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_rsp_q.push_back(apply_request(req_i.func, req_i.value, req_i.priority_req));
      end
      err_count_o <= errors;
      pending_o <= expected_rsp_q.size();
    end
  end

endmodule

// File: tb/sv/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned Capacity = DefaultCapacity;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 4;

  // Priorities for the directed fill: both extremes, zero, and repeated keys.
  localparam logic signed [DataW-1:0] EdgePrios [12] = '{
    32'sd0, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd5, 32'sd5,
    32'sd5, 32'h8000_0001, 32'h7FFF_FFFE, 32'sd1, 32'sd0, 32'h8000_0000
  };
  localparam logic signed [DataW-1:0] EdgeValues [4] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, -32'sd1
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned err_count;
  int unsigned pending;
  int unsigned idle_cycles;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_bus),
    .out_o (rsp_bus)
  );

  spq_order_checker #(
    .Capacity(Capacity)
  ) order_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_i      (rsp_bus),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request beat and hold it until the queue takes it.
  task automatic send_request(input func_e op, input logic signed [DataW-1:0] val,
                              input logic signed [DataW-1:0] pri, input int unsigned gap);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= op;
    req_bus.value <= val;
    req_bus.priority_req <= pri;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Response side: random stalls with stretches of steady draining.
  initial begin
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned r;
    stall_left = 0;
    steady_left = 0;
    rsp_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if (steady_left != 0) begin
        rsp_bus.ready <= 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          steady_left = $urandom_range(20, 80);
          rsp_bus.ready <= 1'b1;
        end else if (r < 70) begin
          rsp_bus.ready <= 1'b1;
        end else begin
          stall_left = pick_gap();
          rsp_bus.ready <= 1'b0;
        end
      end
    end
  end

  // Request side: directed corners first, then random phases.
  initial begin
    int unsigned insert_pct;
    bit          steady;
    func_e       op;
    logic signed [DataW-1:0] pri;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_INSERT;
    req_bus.value = '0;
    req_bus.priority_req = '0;
    wait (rst_ni);
    @(posedge clk_i);

    // Remove from the empty queue, fill it to the brim, overfill, drain a bit.
    send_request(FUNC_REMOVE, 32'sd0, 32'sd0, 0);
    for (int i = 0; i < Capacity; i++) begin
      send_request(FUNC_INSERT, (i < 4) ? EdgeValues[i] : 32'(i * 7919),
                   EdgePrios[i % 12], pick_gap());
    end
    send_request(FUNC_INSERT, 32'sd77, 32'h8000_0000, 0);
    repeat (4) send_request(FUNC_REMOVE, $urandom, $urandom, pick_gap());

    // Each phase leans toward inserts or removes, or mixes them evenly, so that the queue visits
    // both full and empty; keys often collide to exercise newest-first ties.
    for (int ph = 0; ph < 25; ph++) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 25;
        1: insert_pct = 50;
        2: insert_pct = 75;
        default: insert_pct = 90;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 40; k++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pri = $signed(32'($urandom_range(0, 15))) - 32'sd8;
          4: pri = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: pri = $urandom;
        endcase
        send_request(op, $urandom, pri, steady ? 0 : pick_gap());
      end
    end
    req_bus.valid <= 1'b0;

    // Let the last response through, then a short tail for stray beats.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/spq_order_checker.sv
tb/sv/sorted_priority_queue_tb.sv
